@@ sv/essc_pkg.sv @@
// Shared types, codes and reset values for the end-switch shuttle stepper control.
package essc_pkg;

  localparam int CntW = 16;

  // Item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_PIN  = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LOCKOUT_TICKS  = 2'd0;
  localparam logic [1:0] REG_RETREAT_TOGGLE = 2'd1;
  localparam logic [1:0] REG_RETREAT_PERIOD = 2'd2;
  localparam logic [1:0] REG_CONFIRM_POLLS  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CntW-1:0] LOCKOUT_TICKS_RST  = 16'd750;
  localparam logic [CntW-1:0] RETREAT_TOGGLE_RST = 16'd250;
  localparam logic [CntW-1:0] RETREAT_PERIOD_RST = 16'd8;
  localparam logic [1:0]      CONFIRM_POLLS_RST  = 2'd2;

  typedef struct packed {
    logic [CntW-1:0] lockout_ticks;
    logic [CntW-1:0] retreat_toggles;
    logic [CntW-1:0] retreat_period_ticks;
    logic [1:0]      confirm_polls;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       button_low;
    logic       end_one_low;
    logic       end_two_low;
  } item_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic running;
    logic locked;
    logic retreating;
  } levels_t;

endpackage

@@ sv/endstop_shuttle_stepper_control.sv @@
// Top level of the end-switch shuttle stepper control: item and result registers.
//
// Each item (timer tick, pin change or end-switch poll, with the sampled pin
// levels) yields exactly one result: the step, direction, running, lockout and
// retreat levels after that item. An accepted item sits in the input register
// while the state update runs over it as one short pass. The levels land in the
// result register when the held item advances, which waits while a result stalls.
// One item is taken per cycle for as long as results are taken.
// The input register and the result register part the two sides: while a
// result waits under stall, one more item is still taken and held. Configuration
// writes are accepted on every cycle (ready is tied high) and must only be made
// while the block is idle. No clearing pass follows reset.
module endstop_shuttle_stepper_control
  import essc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // configuration write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [CntW-1:0] cfg_data,
  // item channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      kind,
  input  logic            button_low,
  input  logic            end_one_low,
  input  logic            end_two_low,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic            step_level,
  output logic            dir_level,
  output logic            running,
  output logic            locked,
  output logic            retreating
);

  cfg_t    cfg;
  item_t   item;
  logic    item_full;
  levels_t levels_next;
  levels_t res;
  logic    advance;
  logic    take;

  essc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held item when the result register is free or being emptied
  assign advance  = item_full && (!out_valid || !out_stall);
  assign in_stall = item_full && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (take) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  // hold the item payload until it advances
  always_ff @(posedge clk) begin
    if (take) begin
      item.kind        <= kind;
      item.button_low  <= button_low;
      item.end_one_low <= end_one_low;
      item.end_two_low <= end_two_low;
    end
  end

  essc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (advance),
    .item        (item),
    .cfg         (cfg),
    .levels_next (levels_next)
  );

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= levels_next;
    end
  end

  assign step_level = res.step_level;
  assign dir_level  = res.dir_level;
  assign running    = res.running;
  assign locked     = res.locked;
  assign retreating = res.retreating;

  // the motor never runs while it retreats
  a_run_not_retreat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(running && retreating))
    else $error("running and retreating both set");

  // a retreat always sits under a lockout
  a_retreat_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && retreating |-> locked)
    else $error("retreat without lockout");

  // an item that advances always leaves a result behind
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item produced no result");

  // a held item is not lost while the result side stalls
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_full && !advance |=> item_full)
    else $error("held item dropped");

endmodule

@@ sv/essc_cfg_regs.sv @@
// Configuration register file: lockout, retreat and confirmation settings.
module essc_cfg_regs
  import essc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [CntW-1:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ticks        <= LOCKOUT_TICKS_RST;
      cfg.retreat_toggles      <= RETREAT_TOGGLE_RST;
      cfg.retreat_period_ticks <= RETREAT_PERIOD_RST;
      cfg.confirm_polls        <= CONFIRM_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCKOUT_TICKS:  cfg.lockout_ticks        <= cfg_data;
        REG_RETREAT_TOGGLE: cfg.retreat_toggles      <= cfg_data;
        REG_RETREAT_PERIOD: cfg.retreat_period_ticks <= cfg_data;
        REG_CONFIRM_POLLS:  cfg.confirm_polls        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/essc_core.sv @@
// Controller state and its single-pass update for one item.
module essc_core
  import essc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  input  cfg_t    cfg,
  output levels_t levels_next
);

  logic            run_flag,      run_flag_next;
  logic            dir_bit,       dir_bit_next;
  logic            step_bit,      step_bit_next;
  logic            lock_flag,     lock_flag_next;
  logic [CntW-1:0] lock_count,    lock_count_next;
  logic [1:0]      confirm_count, confirm_count_next;
  logic            retreat_flag,  retreat_flag_next;
  logic [CntW-1:0] retreat_left,  retreat_left_next;
  logic [CntW-1:0] retreat_timer, retreat_timer_next;

  logic [CntW-1:0] timer_inc;
  logic [CntW-1:0] lock_inc;
  logic [1:0]      confirm_inc;
  logic [1:0]      confirm_need;
  logic            poll_hit;
  logic            dir_turn;

  assign timer_inc    = retreat_timer + 1'b1;
  assign lock_inc     = lock_count + 1'b1;
  assign confirm_inc  = confirm_count + 1'b1;
  assign confirm_need = (cfg.confirm_polls == 2'd0) ? 2'd1 : cfg.confirm_polls;
  assign poll_hit     = (item.end_one_low || item.end_two_low) && run_flag && !lock_flag;
  // end switch two turns a high direction low before end switch one is judged
  assign dir_turn     = (item.end_two_low && dir_bit) ? 1'b0 : dir_bit;

  always_comb begin
    run_flag_next      = run_flag;
    dir_bit_next       = dir_bit;
    step_bit_next      = step_bit;
    lock_flag_next     = lock_flag;
    lock_count_next    = lock_count;
    confirm_count_next = confirm_count;
    retreat_flag_next  = retreat_flag;
    retreat_left_next  = retreat_left;
    retreat_timer_next = retreat_timer;

    case (item.kind)
      KIND_TICK: begin
        if (retreat_flag) begin
          retreat_timer_next = timer_inc;
          if (timer_inc >= cfg.retreat_period_ticks) begin
            retreat_timer_next = '0;
            if (retreat_left != '0) begin
              step_bit_next     = !step_bit;
              retreat_left_next = retreat_left - 1'b1;
            end else begin
              retreat_flag_next = 1'b0;
              dir_bit_next      = 1'b0;
              step_bit_next     = 1'b0;
              lock_flag_next    = 1'b1;
              lock_count_next   = '0;
            end
          end
        end else begin
          lock_count_next = lock_inc;
          if (lock_inc == cfg.lockout_ticks) begin
            lock_flag_next  = 1'b0;
            lock_count_next = '0;
          end
          if (run_flag) begin
            step_bit_next = !step_bit;
          end
        end
      end
      KIND_PIN: begin
        if (!retreat_flag && item.button_low && !lock_flag) begin
          if (!run_flag) begin
            run_flag_next = 1'b1;
            dir_bit_next  = 1'b1;
          end else begin
            run_flag_next = 1'b0;
            dir_bit_next  = 1'b0;
            step_bit_next = 1'b0;
          end
          lock_flag_next  = 1'b1;
          lock_count_next = '0;
        end
      end
      KIND_POLL: begin
        if (!retreat_flag) begin
          if (!poll_hit) begin
            confirm_count_next = '0;
          end else if (confirm_inc < confirm_need) begin
            confirm_count_next = confirm_inc;
          end else begin
            dir_bit_next = dir_turn;
            if (item.end_one_low && !dir_turn) begin
              run_flag_next      = 1'b0;
              dir_bit_next       = 1'b1;
              retreat_flag_next  = 1'b1;
              retreat_left_next  = cfg.retreat_toggles;
              retreat_timer_next = '0;
            end
            confirm_count_next = '0;
            lock_flag_next     = 1'b1;
            lock_count_next    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag      <= 1'b0;
      dir_bit       <= 1'b0;
      step_bit      <= 1'b0;
      lock_flag     <= 1'b0;
      lock_count    <= '0;
      confirm_count <= '0;
      retreat_flag  <= 1'b0;
      retreat_left  <= '0;
      retreat_timer <= '0;
    end else if (go) begin
      run_flag      <= run_flag_next;
      dir_bit       <= dir_bit_next;
      step_bit      <= step_bit_next;
      lock_flag     <= lock_flag_next;
      lock_count    <= lock_count_next;
      confirm_count <= confirm_count_next;
      retreat_flag  <= retreat_flag_next;
      retreat_left  <= retreat_left_next;
      retreat_timer <= retreat_timer_next;
    end
  end

  assign levels_next.step_level = step_bit_next;
  assign levels_next.dir_level  = dir_bit_next;
  assign levels_next.running    = run_flag_next;
  assign levels_next.locked     = lock_flag_next;
  assign levels_next.retreating = retreat_flag_next;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the end-switch shuttle stepper control.
module testbench;
  import essc_pkg::*;

  // Kind code that the block must treat as a no-op.
  localparam logic [1:0] KIND_NONE = 2'd3;
  // Cycles of silence on every channel before the run is declared hung.
  localparam int QuietLimit = 500;
  // Cycles to keep watching for stray results after the last expected one.
  localparam int TailCycles = 8;
  localparam int ReportMax  = 10;

  // Predictor copy of the controller state.
  typedef struct {
    logic        run;
    logic        dir;
    logic        step;
    logic        lock;
    logic [15:0] lock_cnt;
    logic [1:0]  confirm_cnt;
    logic        retreat;
    logic [15:0] retreat_left;
    logic [15:0] retreat_timer;
  } motor_t;

  logic            clk;
  logic            rst;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [CntW-1:0] cfg_data;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      kind;
  logic            button_low;
  logic            end_one_low;
  logic            end_two_low;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            step_level;
  logic            dir_level;
  logic            running;
  logic            locked;
  logic            retreating;

  motor_t  mtr;
  cfg_t    cfg_shadow;
  levels_t levels_due[$];
  int      fault_count = 0;
  int      stall_left  = 0;
  bit      steady_flow = 1'b0;

  endstop_shuttle_stepper_control u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .button_low  (button_low),
    .end_one_low (end_one_low),
    .end_two_low (end_two_low),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .step_level  (step_level),
    .dir_level   (dir_level),
    .running     (running),
    .locked      (locked),
    .retreating  (retreating)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next item, or stall cycles after a result;
  // none at all during a steady stretch.
  function automatic int draw_pause();
    return steady_flow ? 0 : $urandom_range(0, 8);
  endfunction

  // Advance the predicted controller by one item and return the levels after it.
  function automatic levels_t advance_motor(item_t it);
    logic [1:0] need;
    case (it.kind)
      KIND_TICK: begin
        if (mtr.retreat) begin
          // Only the retreat pacing runs; the lockout counter is frozen.
          mtr.retreat_timer = mtr.retreat_timer + 16'd1;
          if (mtr.retreat_timer >= cfg_shadow.retreat_period_ticks) begin
            mtr.retreat_timer = '0;
            if (mtr.retreat_left != 0) begin
              mtr.step         = ~mtr.step;
              mtr.retreat_left = mtr.retreat_left - 16'd1;
            end else begin
              mtr.retreat  = 1'b0;
              mtr.dir      = 1'b0;
              mtr.step     = 1'b0;
              mtr.lock     = 1'b1;
              mtr.lock_cnt = '0;
            end
          end
        end else begin
          // The counter runs whether or not the lockout holds.
          mtr.lock_cnt = mtr.lock_cnt + 16'd1;
          if (mtr.lock_cnt == cfg_shadow.lockout_ticks) begin
            mtr.lock     = 1'b0;
            mtr.lock_cnt = '0;
          end
          if (mtr.run) mtr.step = ~mtr.step;
        end
      end
      KIND_PIN: begin
        if (!mtr.retreat && it.button_low && !mtr.lock) begin
          if (!mtr.run) begin
            mtr.run = 1'b1;
            mtr.dir = 1'b1;
          end else begin
            mtr.run  = 1'b0;
            mtr.dir  = 1'b0;
            mtr.step = 1'b0;
          end
          mtr.lock     = 1'b1;
          mtr.lock_cnt = '0;
        end
      end
      KIND_POLL: begin
        if (!mtr.retreat) begin
          if (!((it.end_one_low || it.end_two_low) && mtr.run && !mtr.lock)) begin
            mtr.confirm_cnt = '0;
          end else begin
            mtr.confirm_cnt = mtr.confirm_cnt + 2'd1;
            need = (cfg_shadow.confirm_polls == 2'd0) ? 2'd1 : cfg_shadow.confirm_polls;
            if (mtr.confirm_cnt >= need) begin
              // Switch two reverses first, so both switches together can
              // reverse and start the retreat in one poll.
              if (it.end_two_low && mtr.dir) mtr.dir = 1'b0;
              if (it.end_one_low && !mtr.dir) begin
                mtr.run           = 1'b0;
                mtr.dir           = 1'b1;
                mtr.retreat       = 1'b1;
                mtr.retreat_left  = cfg_shadow.retreat_toggles;
                mtr.retreat_timer = '0;
              end
              mtr.confirm_cnt = '0;
              mtr.lock        = 1'b1;
              mtr.lock_cnt    = '0;
            end
          end
        end
      end
      default: ;
    endcase
    return {mtr.step, mtr.dir, mtr.run, mtr.lock, mtr.retreat};
  endfunction

  // Pick the next item from the predicted state so that most of the stream
  // walks the full shuttle: start, reverse at switch two, retreat at switch one.
  function automatic item_t pick_item();
    item_t it;
    int    roll;
    roll           = $urandom_range(0, 99);
    it.kind        = KIND_TICK;
    it.button_low  = 1'($urandom_range(0, 1));
    it.end_one_low = 1'($urandom_range(0, 1));
    it.end_two_low = 1'($urandom_range(0, 1));
    if (roll < 12) begin
      // noise: any kind, unknown one included
      it.kind = 2'($urandom_range(0, 3));
    end else if (mtr.retreat || mtr.lock) begin
      // mostly ticks to run out the retreat or the lockout
      if (roll >= 85) it.kind = 2'($urandom_range(1, 2));
    end else if (!mtr.run) begin
      if (roll < 60) begin
        it.kind       = KIND_PIN;
        it.button_low = 1'b1;
      end
    end else if (roll < 75) begin
      // poll the switch that acts in the present direction
      it.kind = KIND_POLL;
      if (mtr.dir) it.end_two_low = 1'b1;
      else         it.end_one_low = 1'b1;
    end else if (roll >= 92) begin
      it.kind       = KIND_PIN;
      it.button_low = 1'b1;
    end
    return it;
  endfunction

  // Present one item, hold it until taken, then queue its predicted levels.
  // Valid stays high on return; the next call or settle() decides its fate.
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_pause();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    button_low  <= it.button_low;
    end_one_low <= it.end_one_low;
    end_two_low <= it.end_two_low;
    do @(posedge clk); while (in_stall);
    levels_due.push_back(advance_motor(it));
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CntW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOCKOUT_TICKS:  cfg_shadow.lockout_ticks        = data;
      REG_RETREAT_TOGGLE: cfg_shadow.retreat_toggles      = data;
      REG_RETREAT_PERIOD: cfg_shadow.retreat_period_ticks = data;
      REG_CONFIRM_POLLS:  cfg_shadow.confirm_polls        = data[1:0];
      default: ;
    endcase
  endtask

  // Reprogram all registers on an idle block. A lockout already past the new
  // limit would hold until the counter wraps, so first let it expire one tick
  // from now.
  task automatic configure(input logic [CntW-1:0] lockout, input logic [CntW-1:0] toggles,
                           input logic [CntW-1:0] period, input logic [1:0] polls);
    settle();
    if (mtr.lock && !mtr.retreat && lockout <= mtr.lock_cnt) begin
      write_reg(REG_LOCKOUT_TICKS, mtr.lock_cnt + 16'd1);
      cfg_valid <= 1'b0;
      send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
      settle();
    end
    write_reg(REG_LOCKOUT_TICKS, lockout);
    write_reg(REG_RETREAT_TOGGLE, toggles);
    write_reg(REG_RETREAT_PERIOD, period);
    write_reg(REG_CONFIRM_POLLS, {14'd0, polls});
    cfg_valid <= 1'b0;
  endtask

  // Reset values: no-op kind, idle events, start and a press inside the lockout.
  task automatic test_reset_levels();
    send_item({KIND_NONE, 1'b1, 1'b1, 1'b1});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_POLL, 1'b0, 1'b1, 1'b1});
    send_item({KIND_PIN, 1'b0, 1'b1, 1'b1});
    send_item({KIND_PIN, 1'b1, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_PIN, 1'b1, 1'b0, 1'b0});
  endtask

  // Smallest settings: reverse, retreat with events ignored, both switches
  // in one poll, and a stop by button.
  task automatic test_low_extremes();
    configure(16'd1, 16'd1, 16'd1, 2'd1);
    send_item({KIND_POLL, 1'b0, 1'b0, 1'b1});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_POLL, 1'b0, 1'b1, 1'b0});
    send_item({KIND_PIN, 1'b1, 1'b1, 1'b1});
    send_item({KIND_POLL, 1'b1, 1'b1, 1'b1});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_PIN, 1'b1, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_POLL, 1'b0, 1'b1, 1'b1});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_PIN, 1'b1, 1'b0, 1'b0});
    send_item({KIND_TICK, 1'b0, 1'b0, 1'b0});
    send_item({KIND_PIN, 1'b1, 1'b0, 1'b0});
  endtask

  // Random shuttle traffic over several small settings; one phase pauses
  // midway until the block has drained.
  task automatic test_random_shuttle();
    for (int ph = 0; ph < 6; ph++) begin
      configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 4)), 2'($urandom_range(1, 3)));
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(0, 39) == 0) steady_flow = !steady_flow;
        if (ph == 2 && n == 150) settle();
        send_item(pick_item());
      end
    end
    steady_flow = 1'b0;
  endtask

  // Largest settings last: a retreat begun here would outlast the run.
  task automatic test_high_extremes();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    for (int n = 0; n < 30; n++) send_item(pick_item());
  endtask

  function automatic void report_fault(string what, levels_t want, levels_t got);
    fault_count++;
    if (fault_count <= ReportMax)
      $display("%s: expected step=%b dir=%b run=%b lock=%b retreat=%b, got step=%b dir=%b run=%b lock=%b retreat=%b",
               what, want.step_level, want.dir_level, want.running, want.locked,
               want.retreating, got.step_level, got.dir_level, got.running,
               got.locked, got.retreating);
  endfunction

  // Compare each result taken with the oldest prediction.
  always @(posedge clk) begin : result_check
    levels_t got;
    levels_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {step_level, dir_level, running, locked, retreating};
      if (levels_due.size() == 0) begin
        report_fault("result with none pending", 'x, got);
      end else begin
        want = levels_due.pop_front();
        if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
            got.running !== want.running || got.locked !== want.locked ||
            got.retreating !== want.retreating)
          report_fault("level mismatch", want, got);
      end
    end
  end

  // Stall the result side for a drawn number of cycles after each result.
  always @(posedge clk) begin : result_throttle
    int hold;
    if (rst) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      hold = draw_pause();
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end
  end

  // End the run if no channel moves anything for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    kind        <= KIND_TICK;
    button_low  <= 1'b0;
    end_one_low <= 1'b0;
    end_two_low <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_LOCKOUT_TICKS;
    cfg_data    <= '0;
    mtr = '{default: '0};
    cfg_shadow.lockout_ticks        = LOCKOUT_TICKS_RST;
    cfg_shadow.retreat_toggles      = RETREAT_TOGGLE_RST;
    cfg_shadow.retreat_period_ticks = RETREAT_PERIOD_RST;
    cfg_shadow.confirm_polls        = CONFIRM_POLLS_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_levels();
    test_low_extremes();
    test_random_shuttle();
    test_high_extremes();

    // Drain, then watch a little longer for results nobody asked for.
    settle();
    repeat (TailCycles) @(posedge clk);
    if (fault_count == 0 && levels_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
